### rtl/ecq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecq_pkg
// Shared constants and types for the elevator call queue controller.
// ----------------------------------------------------------------------------
package ecq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int FLOOR_BITS  = 6;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LOAD_W      = 16;
  localparam int WEIGHT_W    = 10;

  typedef enum logic [1:0] {
    OP_HALL  = 2'd0,
    OP_ENTRY = 2'd1,
    OP_CONT  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_MOVING  = 2'd1,
    MODE_STOPPED = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    MOT_STILL = 2'd0,
    MOT_UP    = 2'd1,
    MOT_DOWN  = 2'd2
  } motion_e;

  typedef enum logic [1:0] {
    ST_READY = 2'b01,
    ST_PURGE = 2'b10
  } state_e;

  typedef struct packed {
    logic                  push;
    logic [FLOOR_BITS-1:0] wr_floor;
    logic                  shift;
    logic [FLOOR_BITS-1:0] goal;
    logic [CNT_W-1:0]      count;
  } cell_ctrl_t;

endpackage

### rtl/ecq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecq_cell
// One queue slot: holds a floor, takes a push, flags itself as a hole when it
// matches the arrival floor, and shifts in its right neighbor behind a hole.
// ----------------------------------------------------------------------------
module ecq_cell
  import ecq_pkg::*;
(
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [FLOOR_BITS-1:0] nbr_i,
  input  logic                  hole_i,
  output logic [FLOOR_BITS-1:0] entry_o,
  output logic                  hole_o
);

  logic [FLOOR_BITS-1:0] entry_q, entry_d;
  logic                  in_range;
  logic                  my_hole;

  assign in_range = {1'b0, idx_i} < ctrl_i.count;
  assign my_hole  = in_range && (entry_q == ctrl_i.goal);
  assign hole_o   = hole_i | my_hole;
  assign entry_o  = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push && ({1'b0, idx_i} == ctrl_i.count)) begin
      entry_d = ctrl_i.wr_floor;
    end else if (ctrl_i.shift && hole_o) begin
      entry_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### rtl/elevator_call_queue_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_call_queue_controller
// Single-car controller with a FIFO of requested floors kept in a row of cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Hall calls, passenger
// entries and continues that do not arrive give their result in the cycle after
// the request, so a new request can follow every cycle. A continue that makes
// the car arrive purges every queued entry for the arrival floor: the cell row
// removes one matching entry per cycle by shifting the tail left, so the
// result comes only once no matching entry is left, and busy is high
// meanwhile. The result is shown for one cycle with done_o high; the receiver
// cannot stall it and must take it then.
// ----------------------------------------------------------------------------
module elevator_call_queue_controller
  import ecq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            op_i,
  input  logic [5:0]            target_floor_i,
  input  logic [9:0]            weight_entering_i,
  output logic                  done_o,
  output logic [5:0]            floor_now_o,
  output logic [1:0]            motion_o,
  output logic [1:0]            mode_o,
  output logic [5:0]            goal_floor_o,
  output logic [4:0]            pending_o,
  output logic [15:0]           load_kg_o,
  output logic                  dropped_o
);

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [FLOOR_BITS-1:0] car_q, car_d;
  logic [FLOOR_BITS-1:0] goal_q, goal_d;
  mode_e                 mode_q, mode_d;
  motion_e               motion_q, motion_d;
  logic [LOAD_W-1:0]     load_q, load_d;
  logic                  done_q, done_d;
  logic                  dropped_q, dropped_d;

  cell_ctrl_t            ctrl;
  logic [FLOOR_BITS-1:0] entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]  hole;
  logic                  accept;
  logic                  full;
  logic [FLOOR_BITS-1:0] req_floor;
  logic [FLOOR_BITS-1:0] head;
  logic [LOAD_W:0]       load_sum;

  assign accept    = start && (state_q == ST_READY);
  assign full      = count_q >= CNT_W'(QUEUE_DEPTH);
  assign req_floor = FLOOR_BITS'(target_floor_i);
  assign head      = entry[0];
  assign load_sum  = {1'b0, load_q} + (LOAD_W + 1)'(weight_entering_i);
  assign hole[0]   = 1'b0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [FLOOR_BITS-1:0] nbr;
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entry[g+1];
    end
    ecq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(g)),
      .nbr_i   (nbr),
      .hole_i  (hole[g]),
      .entry_o (entry[g]),
      .hole_o  (hole[g+1])
    );
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    car_d     = car_q;
    goal_d    = goal_q;
    mode_d    = mode_q;
    motion_d  = motion_q;
    load_d    = load_q;
    done_d    = 1'b0;
    dropped_d = dropped_q;

    ctrl.push     = 1'b0;
    ctrl.wr_floor = req_floor;
    ctrl.shift    = 1'b0;
    ctrl.goal     = goal_q;
    ctrl.count    = count_q;

    unique case (state_q)
      ST_READY: begin
        if (accept) begin
          dropped_d = 1'b0;
          done_d    = 1'b1;
          unique case (op_e'(op_i))
            OP_HALL: begin
              if (full) begin
                dropped_d = 1'b1;
              end else begin
                ctrl.push = 1'b1;
                count_d   = count_q + 1'b1;
                if (mode_q == MODE_IDLE) begin
                  mode_d   = MODE_MOVING;
                  motion_d = (car_q < req_floor) ? MOT_UP : MOT_DOWN;
                end
              end
            end
            OP_ENTRY: begin
              load_d = load_sum[LOAD_W] ? '1 : load_sum[LOAD_W-1:0];
              if (full) begin
                dropped_d = 1'b1;
              end else begin
                ctrl.push = 1'b1;
                count_d   = count_q + 1'b1;
              end
            end
            OP_CONT: begin
              priority if (mode_q == MODE_IDLE) begin
                if (count_q != '0) begin
                  mode_d   = MODE_MOVING;
                  motion_d = (car_q < head) ? MOT_UP : MOT_DOWN;
                end
              end else if (count_q == '0) begin
                mode_d   = MODE_IDLE;
                motion_d = MOT_STILL;
              end else if (mode_q == MODE_MOVING) begin
                car_d    = head;
                goal_d   = head;
                motion_d = MOT_STILL;
                done_d   = 1'b0;
                state_d  = ST_PURGE;
              end else begin
                mode_d   = MODE_MOVING;
                motion_d = (car_q < head) ? MOT_UP : MOT_DOWN;
              end
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_PURGE: begin
        if (hole[QUEUE_DEPTH]) begin
          ctrl.shift = 1'b1;
          count_d    = count_q - 1'b1;
        end else begin
          mode_d  = (count_q == '0) ? MODE_IDLE : MODE_STOPPED;
          done_d  = 1'b1;
          state_d = ST_READY;
        end
      end
      default: begin
        state_d = ST_READY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_READY;
      count_q   <= '0;
      car_q     <= '0;
      mode_q    <= MODE_IDLE;
      motion_q  <= MOT_STILL;
      load_q    <= '0;
      done_q    <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      car_q     <= car_d;
      mode_q    <= mode_d;
      motion_q  <= motion_d;
      load_q    <= load_d;
      done_q    <= done_d;
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    goal_q <= goal_d;
  end

  assign busy         = (state_q == ST_PURGE);
  assign done_o       = done_q;
  assign floor_now_o  = 6'(car_q);
  assign motion_o     = motion_q;
  assign mode_o       = mode_q;
  assign goal_floor_o = (count_q != '0) ? 6'(head) : 6'd0;
  assign pending_o    = 5'(count_q);
  assign load_kg_o    = load_q;
  assign dropped_o    = dropped_q;

endmodule
